### src/u8u16_pkg.sv
// UTF-8 to UTF-16 decoder package: result status codes, decode constants
// and the result transaction struct. No dependencies.
`default_nettype none

package u8u16_pkg;

   localparam int unsigned CpWidth   = 31;
   localparam int unsigned UnitWidth = 16;

   localparam logic [2:0] STATUS_UNIT       = 3'd0;
   localparam logic [2:0] STATUS_BAD_LEAD   = 3'd1;
   localparam logic [2:0] STATUS_BROKEN     = 3'd2;
   localparam logic [2:0] STATUS_ILLEGAL    = 3'd3;
   localparam logic [2:0] STATUS_INCOMPLETE = 3'd4;

   localparam logic [CpWidth-1:0] BOM_VALUE      = 31'h0000_FEFF;
   localparam logic [CpWidth-1:0] MAX_CODE_POINT = 31'h0010_FFFF;
   localparam logic [CpWidth-1:0] SURR_MASK      = 31'h7FFF_F800;
   localparam logic [CpWidth-1:0] SURR_BASE      = 31'h0000_D800;
   localparam logic [CpWidth-1:0] MIN_LEN2       = 31'h0000_0080;
   localparam logic [CpWidth-1:0] MIN_LEN3       = 31'h0000_0800;
   localparam logic [CpWidth-1:0] MIN_LEN4       = 31'h0001_0000;
   localparam logic [CpWidth-1:0] BMP_MAX        = 31'h0000_FFFF;
   localparam logic [20:0]        PLANE_OFFSET   = 21'h01_0000;
   localparam logic [5:0]         HIGH_SURR_TAG  = 6'b110110;
   localparam logic [5:0]         LOW_SURR_TAG   = 6'b110111;

   typedef struct packed {
      logic [UnitWidth-1:0] code_unit;
      logic [2:0]           status;
      logic                 byte_consumed;
      logic                 last_result;
   } result_type;

endpackage

`default_nettype wire

### src/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 decoder core: input register, single-pass decode, result
// register with one overflow slot for the second half of a surrogate pair.
// Depends on u8u16_pkg.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   req     | in        | req_valid, req_stall, req_in_byte, req_end_of_buffer
//   rsp     | out       | rsp_valid, rsp_stall, rsp_code_unit, rsp_status,
//           |           | rsp_byte_consumed, rsp_last_result
//
// One byte per cycle while req_stall is low; a result passes through the input register and then the result register.
// A surrogate pair holds the input register while the
// overflow slot drains. Synchronous reset restores the stream-start state.
// rsp_stall backs up through the result register into req_stall.
`default_nettype none

module utf8_to_utf16_decoder_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_in_byte,
   input  wire logic                            req_end_of_buffer,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [u8u16_pkg::UnitWidth-1:0]      rsp_code_unit,
   output logic [2:0]                           rsp_status,
   output logic                                 rsp_byte_consumed,
   output logic                                 rsp_last_result
);
   import u8u16_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_byte_ff, s1_byte_in;
   logic                 s1_eob_ff, s1_eob_in;

   logic [CpWidth-1:0]   cp_ff, cp_in;
   logic [2:0]           rem_ff, rem_in;
   logic [2:0]           len_ff, len_in;
   logic                 start_ff, start_in;

   result_type           rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;

   logic                 out_free;
   logic                 advance;
   logic                 accept;

   logic [1:0]           res_cnt;
   result_type           res0, res1;
   logic [CpWidth-1:0]   cont_bits, cp_merge;
   logic [4:0]           shamt;
   logic [2:0]           rem_dec;
   logic                 cp_bad;
   logic [20:0]          plane_val;
   logic                 open_after;
   result_type           unit_res, err_res, inc_res;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && !pend_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_eob_in   = s1_eob_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_in_byte;
         s1_eob_in   = req_end_of_buffer;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rem_dec   = rem_ff - 3'd1;
      unique case (rem_dec)
         3'd0:    shamt = 5'd0;
         3'd1:    shamt = 5'd6;
         3'd2:    shamt = 5'd12;
         3'd3:    shamt = 5'd18;
         3'd4:    shamt = 5'd24;
         default: shamt = 5'd30;
      endcase
      cont_bits = {{(CpWidth-6){1'b0}}, s1_byte_ff[5:0]};
      cp_merge  = cp_ff | (cont_bits << shamt);

      cp_bad = 1'b0;
      if (len_ff == 3'd2 && cp_merge < MIN_LEN2) cp_bad = 1'b1;
      if (len_ff == 3'd3 && cp_merge < MIN_LEN3) cp_bad = 1'b1;
      if (len_ff == 3'd4 && cp_merge < MIN_LEN4) cp_bad = 1'b1;
      if (len_ff > 3'd4 || len_ff < 3'd2)        cp_bad = 1'b1;
      if ((cp_merge & SURR_MASK) == SURR_BASE)   cp_bad = 1'b1;
      if (cp_merge > MAX_CODE_POINT)             cp_bad = 1'b1;

      plane_val = cp_merge[20:0] - PLANE_OFFSET;
   end

   always_comb begin
      cp_in    = cp_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      start_in = start_ff;
      res_cnt  = 2'd0;
      open_after = 1'b0;

      unit_res = '{code_unit: '0, status: STATUS_UNIT, byte_consumed: 1'b1,
                   last_result: 1'b0};
      err_res  = '{code_unit: '0, status: STATUS_BAD_LEAD, byte_consumed: 1'b1,
                   last_result: 1'b1};
      inc_res  = '{code_unit: '0, status: STATUS_INCOMPLETE, byte_consumed: 1'b1,
                   last_result: 1'b1};
      res0 = unit_res;
      res1 = unit_res;

      if (rem_ff == 3'd0) begin
         priority casez (s1_byte_ff)
            8'b0???????: begin
               res0.code_unit = {8'h00, s1_byte_ff};
               res_cnt  = 2'd1;
               len_in   = 3'd1;
               start_in = 1'b0;
            end
            8'b110?????: begin
               cp_in  = {20'd0, s1_byte_ff[4:0], 6'd0};
               rem_in = 3'd1;
               len_in = 3'd2;
            end
            8'b1110????: begin
               cp_in  = {15'd0, s1_byte_ff[3:0], 12'd0};
               rem_in = 3'd2;
               len_in = 3'd3;
            end
            8'b11110???: begin
               cp_in  = {10'd0, s1_byte_ff[2:0], 18'd0};
               rem_in = 3'd3;
               len_in = 3'd4;
            end
            8'b111110??: begin
               cp_in  = {5'd0, s1_byte_ff[1:0], 24'd0};
               rem_in = 3'd4;
               len_in = 3'd5;
            end
            8'b1111110?: begin
               cp_in  = {s1_byte_ff[0], 30'd0};
               rem_in = 3'd5;
               len_in = 3'd6;
            end
            default: begin
               res0 = err_res;
               res_cnt = 2'd1;
            end
         endcase
         open_after = (res_cnt == 2'd0);
      end else if (s1_byte_ff[7:6] == 2'b10) begin
         cp_in  = cp_merge;
         rem_in = rem_dec;
         if (rem_dec == 3'd0) begin
            if (cp_bad) begin
               res0 = err_res;
               res0.status = STATUS_ILLEGAL;
               res_cnt = 2'd1;
            end else begin
               if (cp_merge > BMP_MAX) begin
                  res0.code_unit = {HIGH_SURR_TAG, plane_val[19:10]};
                  res1.code_unit = {LOW_SURR_TAG, plane_val[9:0]};
                  res_cnt = 2'd2;
               end else if (cp_merge != BOM_VALUE || !start_ff) begin
                  res0.code_unit = cp_merge[UnitWidth-1:0];
                  res_cnt = 2'd1;
               end
               cp_in    = '0;
               len_in   = 3'd1;
               start_in = 1'b0;
            end
         end else begin
            open_after = 1'b1;
         end
      end else begin
         res0 = err_res;
         res0.status        = STATUS_BROKEN;
         res0.byte_consumed = 1'b0;
         res_cnt = 2'd1;
      end

      if (res0.status != STATUS_UNIT) begin
         cp_in    = '0;
         rem_in   = 3'd0;
         len_in   = 3'd1;
         start_in = 1'b1;
      end

      if (open_after && s1_eob_ff) begin
         res0    = inc_res;
         res_cnt = 2'd1;
      end else if (res_cnt == 2'd2) begin
         res1.last_result = 1'b1;
      end else begin
         res0.last_result = 1'b1;
      end
   end

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (pend_valid_ff && out_free) begin
         rsp_in        = pend_ff;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end else if (advance) begin
         rsp_in       = res0;
         rsp_valid_in = (res_cnt != 2'd0);
         if (res_cnt == 2'd2) begin
            pend_in       = res1;
            pend_valid_in = 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         cp_ff         <= '0;
         rem_ff        <= 3'd0;
         len_ff        <= 3'd1;
         start_ff      <= 1'b1;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (advance) begin
            cp_ff    <= cp_in;
            rem_ff   <= rem_in;
            len_ff   <= len_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_eob_ff  <= s1_eob_in;
      rsp_ff     <= rsp_in;
      pend_ff    <= pend_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_unit     = rsp_ff.code_unit;
   assign rsp_status        = rsp_ff.status;
   assign rsp_byte_consumed = rsp_ff.byte_consumed;
   assign rsp_last_result   = rsp_ff.last_result;

endmodule

`default_nettype wire
